[rtl/core/tofzp_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofzp_pkg
// Shared types, register codes and tables of the time-of-flight zone
// presence tracker.
// ----------------------------------------------------------------------------
package tofzp_pkg;

    localparam int DIST_W   = 16;
    localparam int FACTOR_W = 16;
    localparam int ZONE_W   = 6;
    localparam int COUNT_W  = 7;
    localparam int ROW_W    = 4;
    localparam int RPR_W    = 4;
    localparam int STATUS_W = 2;
    localparam int RING_W   = 3;
    localparam int PROD_W   = DIST_W + FACTOR_W;
    localparam int CFG_IDX_W = 3;

    localparam logic [DIST_W-1:0]   NEAR_LIMIT_RST = 16'd100;
    localparam logic [DIST_W-1:0]   FAR_LIMIT_RST  = 16'd4000;
    localparam logic [FACTOR_W-1:0] NOISE_HIGH_RST = 16'd282;
    localparam logic [FACTOR_W-1:0] NOISE_LOW_RST  = 16'd230;
    localparam logic [RPR_W-1:0]    ROW_SIZE_RST   = 4'd8;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_NEAR_LIMIT    = 3'd0,
        REG_FAR_LIMIT     = 3'd1,
        REG_NOISE_HIGH    = 3'd2,
        REG_NOISE_LOW     = 3'd3,
        REG_ZONES_PER_ROW = 3'd4
    } cfg_reg_t;

    localparam logic [STATUS_W-1:0] STATUS_INIT    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_ACQUIRE = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_ANIMAL  = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_CAPTURE = 2'd3;

    typedef struct packed {
        logic [DIST_W-1:0]   near_limit;
        logic [DIST_W-1:0]   far_limit;
        logic [FACTOR_W-1:0] noise_high;
        logic [FACTOR_W-1:0] noise_low;
        logic [RPR_W-1:0]    zones_per_row;
    } cfg_t;

    // Zone as it leaves the background read.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              eval;
        logic [DIST_W-1:0] zone_dist;
        logic [ZONE_W-1:0] idx;
    } rd_stage_t;

    // Zone with its scaled background thresholds.
    typedef struct packed {
        logic              valid;
        logic              last;
        logic              eval;
        logic              in_range;
        logic [DIST_W-1:0] zone_dist;
        logic [ZONE_W-1:0] idx;
        logic [ROW_W-1:0]  row;
        logic [PROD_W-1:0] high_thr;
        logic [PROD_W-1:0] low_thr;
    } eval_stage_t;

    localparam logic [RING_W-1:0] RING_OF_ZONE [64] = '{
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4,
        3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4,
        3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd3, 3'd2, 3'd1, 3'd0, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd3, 3'd2, 3'd1, 3'd1, 3'd1, 3'd2, 3'd3, 3'd4,
        3'd3, 3'd2, 3'd2, 3'd2, 3'd2, 3'd2, 3'd3, 3'd4,
        3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd3, 3'd4,
        3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4, 3'd4
    };

    // Row of a zone; row size saturates to 4..8. Sizes 5 to 7 use a
    // reciprocal multiply that is exact for indexes below 64.
    function automatic logic [ROW_W-1:0] row_of(input logic [ZONE_W-1:0] idx,
                                                 input logic [RPR_W-1:0]  rs);
        logic [13:0] prod;
        logic [ROW_W-1:0] row;
        prod = 14'd0;
        row  = 4'(idx >> 3);
        case (rs)
            4'd5: begin
                prod = 14'(idx) * 14'd205;
                row  = prod[13:10];
            end
            4'd6: begin
                prod = 14'(idx) * 14'd171;
                row  = prod[13:10];
            end
            4'd7: begin
                prod = 14'(idx) * 14'd147;
                row  = prod[13:10];
            end
            default: begin
                if (rs <= 4'd4) begin
                    row = 4'(idx >> 2);
                end else begin
                    row = 4'(idx >> 3);
                end
            end
        endcase
        return row;
    endfunction

endpackage

[rtl/core/tofzp_bg_mem.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofzp_bg_mem
// Background distance store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module tofzp_bg_mem #(
    parameter int DEPTH  = 64,
    parameter int ADDR_W = 6
) (
    input  logic                        aclk,
    input  logic                        wr_en,
    input  logic [ADDR_W-1:0]           wr_addr,
    input  logic [tofzp_pkg::DIST_W-1:0] wr_data,
    input  logic                        rd_en,
    input  logic [ADDR_W-1:0]           rd_addr,
    output logic [tofzp_pkg::DIST_W-1:0] rd_data_reg
);
    import tofzp_pkg::*;

    logic [DIST_W-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge aclk) begin
        if (rd_en) begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/tofzp_scale.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofzp_scale
// Scales the background by the noise factors and checks the distance window.
// ----------------------------------------------------------------------------
module tofzp_scale (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         adv,
    input  tofzp_pkg::cfg_t              cfg,
    input  tofzp_pkg::rd_stage_t         rd_stage,
    input  logic [tofzp_pkg::DIST_W-1:0] bg_data,
    output tofzp_pkg::eval_stage_t       eval_reg
);
    import tofzp_pkg::*;

    eval_stage_t eval_next;

    always_comb begin
        eval_next.valid     = rd_stage.valid;
        eval_next.last      = rd_stage.last;
        eval_next.eval      = rd_stage.eval;
        eval_next.zone_dist = rd_stage.zone_dist;
        eval_next.idx       = rd_stage.idx;
        eval_next.in_range  = (rd_stage.zone_dist > cfg.near_limit) &&
                              (rd_stage.zone_dist < cfg.far_limit);
        eval_next.row       = row_of(rd_stage.idx, cfg.zones_per_row);
        eval_next.high_thr  = PROD_W'(cfg.noise_high) * PROD_W'(bg_data);
        eval_next.low_thr   = PROD_W'(cfg.noise_low) * PROD_W'(bg_data);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eval_reg.valid <= 1'b0;
        end else if (adv) begin
            eval_reg <= eval_next;
        end
    end

endmodule

[rtl/core/tofzp_track.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tofzp_track
// Per-frame nearest-zone search, mode sequencing and result register.
// ----------------------------------------------------------------------------
module tofzp_track #(
    parameter int MAX_ZONES = 64
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  tofzp_pkg::cfg_t                cfg,
    input  tofzp_pkg::eval_stage_t         eval_stage,
    output logic                           hold,
    output logic                           m_valid,
    input  logic                           m_ready,
    output logic [tofzp_pkg::STATUS_W-1:0] m_status,
    output logic                           m_nearest_valid,
    output logic [tofzp_pkg::ZONE_W-1:0]   m_nearest_zone,
    output logic [tofzp_pkg::COUNT_W-1:0]  m_changed_count,
    output logic                           m_previous_valid,
    output logic [tofzp_pkg::ZONE_W-1:0]   m_previous_zone,
    output logic [tofzp_pkg::RING_W-1:0]   m_center_distance
);
    import tofzp_pkg::*;

    typedef enum logic [1:0] {
        MODE_INIT    = 2'd0,
        MODE_ACQUIRE = 2'd1,
        MODE_ANIMAL  = 2'd2
    } mode_t;

    mode_t             mode_reg, mode_next;
    logic              cap_reg, cap_next;
    logic [DIST_W-1:0] min_reg, min_next;
    logic [ZONE_W-1:0] min_zone_reg, min_zone_next;
    logic              found_reg, found_next;
    logic [COUNT_W-1:0] count_reg, count_next;
    logic              cur_valid_reg, cur_valid_next;
    logic [ZONE_W-1:0] cur_zone_reg, cur_zone_next;
    logic              prev_valid_reg, prev_valid_next;
    logic [ZONE_W-1:0] prev_zone_reg, prev_zone_next;
    logic              m_valid_reg;

    logic [PROD_W-1:0]   scaled;
    logic [ROW_W-1:0]    min_row;
    logic                checking, changed, take, report, step, load;
    logic [STATUS_W-1:0] status_next;

    assign hold = eval_stage.valid && eval_stage.last && m_valid_reg && !m_ready;
    assign step = eval_stage.valid && !hold;
    assign load = step && eval_stage.last;

    always_comb begin
        scaled   = {8'd0, eval_stage.zone_dist, 8'd0};
        min_row  = row_of(min_zone_reg, cfg.zones_per_row);
        checking = (mode_reg != MODE_INIT) && !cap_reg;
        changed  = eval_stage.eval && checking && eval_stage.in_range &&
                   ((scaled > eval_stage.high_thr) || (scaled < eval_stage.low_thr));
        // Equal distance wins only inside the row of the kept zone.
        take     = changed && ((eval_stage.zone_dist < min_reg) ||
                   (found_reg && (eval_stage.zone_dist == min_reg) &&
                    (eval_stage.row == min_row)));

        min_next      = take ? eval_stage.zone_dist : min_reg;
        min_zone_next = take ? eval_stage.idx : min_zone_reg;
        found_next    = found_reg || take;
        count_next    = count_reg + COUNT_W'(changed);

        mode_next       = mode_reg;
        cap_next        = cap_reg;
        cur_valid_next  = cur_valid_reg;
        cur_zone_next   = cur_zone_reg;
        prev_valid_next = prev_valid_reg;
        prev_zone_next  = prev_zone_reg;
        report          = 1'b0;
        status_next     = STATUS_INIT;
        case (mode_reg)
            MODE_INIT: begin
                status_next = STATUS_INIT;
                mode_next   = MODE_ACQUIRE;
            end
            default: begin
                if (cap_reg) begin
                    // Frame after a capture: back to acquisition unchecked.
                    status_next = STATUS_ACQUIRE;
                    mode_next   = MODE_ACQUIRE;
                    cap_next    = 1'b0;
                end else begin
                    report = 1'b1;
                    if (found_next) begin
                        prev_valid_next = cur_valid_reg;
                        prev_zone_next  = cur_zone_reg;
                        cur_valid_next  = 1'b1;
                        cur_zone_next   = min_zone_next;
                        mode_next       = MODE_ANIMAL;
                        status_next     = STATUS_ANIMAL;
                    end else if (mode_reg == MODE_ACQUIRE) begin
                        status_next = STATUS_ACQUIRE;
                    end else begin
                        cap_next    = 1'b1;
                        status_next = STATUS_CAPTURE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg       <= MODE_INIT;
            cap_reg        <= 1'b0;
            min_reg        <= FAR_LIMIT_RST;
            min_zone_reg   <= '0;
            found_reg      <= 1'b0;
            count_reg      <= '0;
            cur_valid_reg  <= 1'b0;
            cur_zone_reg   <= '0;
            prev_valid_reg <= 1'b0;
            prev_zone_reg  <= '0;
            m_valid_reg    <= 1'b0;
        end else begin
            if (load) begin
                // Close the frame and restart the search.
                mode_reg       <= mode_next;
                cap_reg        <= cap_next;
                cur_valid_reg  <= cur_valid_next;
                cur_zone_reg   <= cur_zone_next;
                prev_valid_reg <= prev_valid_next;
                prev_zone_reg  <= prev_zone_next;
                min_reg        <= cfg.far_limit;
                min_zone_reg   <= '0;
                found_reg      <= 1'b0;
                count_reg      <= '0;

                m_status          <= status_next;
                m_nearest_valid   <= report && found_next;
                m_nearest_zone    <= (report && found_next) ? min_zone_next : '0;
                m_changed_count   <= report ? count_next : '0;
                m_previous_valid  <= prev_valid_next;
                m_previous_zone   <= prev_valid_next ? prev_zone_next : '0;
                m_center_distance <= cur_valid_next ? RING_OF_ZONE[cur_zone_next] : '0;
            end else if (step) begin
                min_reg      <= min_next;
                min_zone_reg <= min_zone_next;
                found_reg    <= found_next;
                count_reg    <= count_next;
            end

            if (load) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    assign m_valid = m_valid_reg;

    a_count_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        count_reg <= COUNT_W'(MAX_ZONES))
        else $error("changed count exceeds zone count");

    a_found_counted: assert property (@(posedge aclk) disable iff (!aresetn)
        found_reg |-> (count_reg != '0))
        else $error("nearest zone kept without a changed zone");

    a_capture_mode: assert property (@(posedge aclk) disable iff (!aresetn)
        cap_reg |-> (mode_reg == MODE_ANIMAL))
        else $error("capture pending outside animal mode");

    a_prev_needs_cur: assert property (@(posedge aclk) disable iff (!aresetn)
        prev_valid_reg |-> cur_valid_reg)
        else $error("previous position without current position");

    a_capture_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        (load && (status_next == STATUS_CAPTURE)) |=> !m_nearest_valid)
        else $error("capture reported with a nearest zone");

endmodule

[rtl/core/tof_zone_presence_tracker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tof_zone_presence_tracker
// Background-subtracting presence tracker over streamed time-of-flight zones.
// ----------------------------------------------------------------------------
// One zone is taken per clock cycle, and frames may follow each other with no
// gap. Each zone passes three register stages: background memory read, noise
// threshold multiply, then the nearest-zone compare and count into the result
// register. The single read port of the background store and the
// combinational compare feeding the running-minimum register set the rate of
// one zone per cycle. The first frame after reset is written to the background
// store and answers status 0. Input stalls only while a frame result waits at
// the output and the next frame's last zone has reached the end of the pipe.
// ----------------------------------------------------------------------------
module tof_zone_presence_tracker #(
    parameter int MAX_ZONES = 64
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            cfg_wr_en,
    input  logic [tofzp_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [tofzp_pkg::DIST_W-1:0]    cfg_wdata,
    input  logic                            s_valid,
    output logic                            s_ready,
    input  logic [tofzp_pkg::DIST_W-1:0]    s_zone_distance,
    input  logic                            s_last_zone,
    output logic                            m_valid,
    input  logic                            m_ready,
    output logic [tofzp_pkg::STATUS_W-1:0]  m_status,
    output logic                            m_nearest_valid,
    output logic [tofzp_pkg::ZONE_W-1:0]    m_nearest_zone,
    output logic [tofzp_pkg::COUNT_W-1:0]   m_changed_count,
    output logic                            m_previous_valid,
    output logic [tofzp_pkg::ZONE_W-1:0]    m_previous_zone,
    output logic [tofzp_pkg::RING_W-1:0]    m_center_distance
);
    import tofzp_pkg::*;

    localparam int ADDR_W = $clog2(MAX_ZONES);
    localparam int CNT_W  = $clog2(MAX_ZONES + 1);

    cfg_t              cfg_reg;
    logic [CNT_W-1:0]  zone_cnt_reg;
    logic              bg_fill_reg;
    rd_stage_t         rd_reg, rd_next;
    eval_stage_t       eval_reg;
    logic [DIST_W-1:0] bg_data;
    logic              hold, adv, accept, in_zone;
    logic [ADDR_W-1:0] zone_addr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.near_limit    <= NEAR_LIMIT_RST;
            cfg_reg.far_limit     <= FAR_LIMIT_RST;
            cfg_reg.noise_high    <= NOISE_HIGH_RST;
            cfg_reg.noise_low     <= NOISE_LOW_RST;
            cfg_reg.zones_per_row <= ROW_SIZE_RST;
        end else if (cfg_wr_en) begin
            case (cfg_index)
                REG_NEAR_LIMIT:    cfg_reg.near_limit    <= cfg_wdata;
                REG_FAR_LIMIT:     cfg_reg.far_limit     <= cfg_wdata;
                REG_NOISE_HIGH:    cfg_reg.noise_high    <= cfg_wdata;
                REG_NOISE_LOW:     cfg_reg.noise_low     <= cfg_wdata;
                REG_ZONES_PER_ROW: cfg_reg.zones_per_row <= cfg_wdata[RPR_W-1:0];
                default: ;
            endcase
        end
    end

    assign adv       = !hold;
    assign s_ready   = adv;
    assign accept    = s_valid && adv;
    assign in_zone   = zone_cnt_reg < CNT_W'(MAX_ZONES);
    assign zone_addr = zone_cnt_reg[ADDR_W-1:0];

    always_comb begin
        rd_next.valid     = accept;
        rd_next.last      = s_last_zone;
        rd_next.eval      = in_zone && !bg_fill_reg;
        rd_next.zone_dist = s_zone_distance;
        rd_next.idx       = ZONE_W'(zone_addr);
    end

    // Writes land on the accept edge and every read is issued by a later
    // zone, so no entry is read while its write is in flight.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            zone_cnt_reg <= '0;
            bg_fill_reg  <= 1'b1;
            rd_reg.valid <= 1'b0;
        end else if (adv) begin
            rd_reg <= rd_next;
            if (accept) begin
                if (s_last_zone) begin
                    zone_cnt_reg <= '0;
                    bg_fill_reg  <= 1'b0;
                end else if (in_zone) begin
                    zone_cnt_reg <= zone_cnt_reg + CNT_W'(1);
                end
            end
        end
    end

    tofzp_bg_mem #(
        .DEPTH  (MAX_ZONES),
        .ADDR_W (ADDR_W)
    ) u_bg_mem (
        .aclk        (aclk),
        .wr_en       (accept && in_zone && bg_fill_reg),
        .wr_addr     (zone_addr),
        .wr_data     (s_zone_distance),
        .rd_en       (accept && in_zone && !bg_fill_reg),
        .rd_addr     (zone_addr),
        .rd_data_reg (bg_data)
    );

    tofzp_scale u_scale (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .adv        (adv),
        .cfg        (cfg_reg),
        .rd_stage   (rd_reg),
        .bg_data    (bg_data),
        .eval_reg   (eval_reg)
    );

    tofzp_track #(
        .MAX_ZONES (MAX_ZONES)
    ) u_track (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg               (cfg_reg),
        .eval_stage        (eval_reg),
        .hold              (hold),
        .m_valid           (m_valid),
        .m_ready           (m_ready),
        .m_status          (m_status),
        .m_nearest_valid   (m_nearest_valid),
        .m_nearest_zone    (m_nearest_zone),
        .m_changed_count   (m_changed_count),
        .m_previous_valid  (m_previous_valid),
        .m_previous_zone   (m_previous_zone),
        .m_center_distance (m_center_distance)
    );

endmodule
